[sv/bgmt_pkg.sv]
`default_nettype none
package bgmt_pkg;

	localparam int FRAME_W  = 640;
	localparam int FRAME_H  = 480;
	localparam int AREA_DIV = 4;

	localparam logic [9:0] BOX_W0 = (FRAME_W > 1023) ? 10'd1023 : 10'(FRAME_W);
	localparam logic [9:0] BOX_H0 = (FRAME_H > 1023) ? 10'd1023 : 10'(FRAME_H);
	localparam logic signed [22:0] AREA_LIM = 23'(FRAME_W * FRAME_H / AREA_DIV);

	localparam logic [23:0] MASS_MAX = 24'hFFFFFF;
	localparam logic [39:0] WSUM_MAX = 40'hFF_FFFF_FFFF;

	localparam logic [2:0] CFG_LOT_BOUND  = 3'd0;
	localparam logic [2:0] CFG_BASE_BOUND = 3'd1;
	localparam logic [2:0] CFG_SOFT_BOUND = 3'd2;
	localparam logic [2:0] CFG_MIN_MASS   = 3'd3;
	localparam logic [2:0] CFG_MAX_MASS   = 3'd4;
	localparam logic [2:0] CFG_RATIO_MIN  = 3'd5;
	localparam logic [2:0] CFG_RATIO_MAX  = 3'd6;
	localparam logic [2:0] CFG_SOFT_RATIO = 3'd7;

	typedef struct packed {
		logic [19:0] mass;
		logic [9:0]  center_x;
		logic [9:0]  center_y;
		logic [9:0]  left_col;
		logic [9:0]  right_col;
		logic [9:0]  top_row;
		logic [9:0]  bottom_row;
		logic [15:0] levity;
		logic        last_blob;
	} blob_t;

	typedef struct packed {
		logic        candidate;
		logic        soft_candidate;
		logic        killed;
		logic [9:0]  track_x;
		logic [9:0]  track_y;
		logic [9:0]  box_left;
		logic [9:0]  box_right;
		logic [9:0]  box_top;
		logic [9:0]  box_bottom;
		logic [23:0] total_mass;
		logic        lost_track;
		logic        frame_done;
	} result_t;

	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic dec;
		logic fin;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic out_busy;
		logic div_done;
	} stat_t;

endpackage
`default_nettype wire

[sv/bgmt_div.sv]
`default_nettype none
module bgmt_div import bgmt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [39:0] num,
	input  wire logic [23:0] den,
	output logic             done,
	output logic [9:0]       quot
);

	logic [39:0] q_q;
	logic [23:0] rem_q;
	logic [23:0] den_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [24:0] trial;
	logic        fits;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, q_q[39]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd39) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= fits ? 24'(trial - {1'b0, den_q}) : trial[23:0];
			q_q   <= {q_q[38:0], fits};
		end
	end

	assign done = done_q;
	assign quot = (|q_q[39:10]) ? 10'd1023 : q_q[9:0];

endmodule
`default_nettype wire

[sv/bgmt_dp.sv]
`default_nettype none
module bgmt_dp import bgmt_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [19:0] cfg_data,
	input  wire blob_t   blob,
	input  wire cmd_t    cmd,
	output stat_t        stat,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	logic [9:0]  lot_q, base_q, softb_q;
	logic [19:0] minm_q, maxm_q;
	logic [15:0] rmin_q, rmax_q;
	logic signed [15:0] softr_q;

	logic        seen_q, lost_q;
	logic [9:0]  prev_x_q, prev_y_q;
	logic [23:0] mass_acc_q;
	logic [39:0] wsum_x_q, wsum_y_q;
	logic [9:0]  bl_q, bt_q, br_q, bb_q;

	blob_t       in_q;
	logic [25:0] bprod_q;
	logic signed [32:0] shift_q;
	logic signed [10:0] w_q, h_q;
	logic [29:0] px_q, py_q;

	logic signed [44:0] low_q, hiw_q;
	logic        killw_q, massbad_q;
	logic        cand_q, soft_q;
	logic signed [22:0] area_q;

	logic [18:0] bound;
	logic [19:0] xhi, xlo, yhi, ylo;
	logic signed [33:0] lo, hi;
	logic signed [26:0] numr;
	logic        ratiobad, cand, soft_ok;
	logic [24:0] msum;
	logic [40:0] wxs, wys;
	logic        dx_done, dy_done;
	logic [9:0]  qx, qy;
	logic        lost_nx;
	logic signed [10:0] adx, ady;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lot_q   <= 10'd150;
			base_q  <= 10'd10;
			softb_q <= 10'd140;
			minm_q  <= 20'd25;
			maxm_q  <= 20'd25000;
			rmin_q  <= 16'd77;
			rmax_q  <= 16'd435;
			softr_q <= -16'sd77;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LOT_BOUND:  lot_q   <= cfg_data[9:0];
				CFG_BASE_BOUND: base_q  <= cfg_data[9:0];
				CFG_SOFT_BOUND: softb_q <= cfg_data[9:0];
				CFG_MIN_MASS:   minm_q  <= cfg_data;
				CFG_MAX_MASS:   maxm_q  <= cfg_data;
				CFG_RATIO_MIN:  rmin_q  <= cfg_data[15:0];
				CFG_RATIO_MAX:  rmax_q  <= cfg_data[15:0];
				CFG_SOFT_RATIO: softr_q <= $signed(cfg_data[15:0]);
				default: ;
			endcase
		end
	end

	// products
	always_ff @(posedge clk) begin
		if (cmd.load) in_q <= blob;
		if (cmd.mul1) begin
			bprod_q <= in_q.levity * softb_q;
			shift_q <= $signed({1'b0, in_q.levity}) * softr_q;
			w_q     <= $signed({1'b0, in_q.right_col}) - $signed({1'b0, in_q.left_col});
			h_q     <= $signed({1'b0, in_q.bottom_row}) - $signed({1'b0, in_q.top_row});
			px_q    <= in_q.mass * in_q.center_x;
			py_q    <= in_q.mass * in_q.center_y;
		end
		if (cmd.mul2) begin
			low_q     <= lo * w_q;
			hiw_q     <= hi * w_q;
			killw_q   <= (xlo < {10'd0, prev_x_q}) || ({10'd0, in_q.center_x} > xhi) ||
			             (ylo < {10'd0, prev_y_q}) || ({10'd0, in_q.center_y} > yhi);
			massbad_q <= (in_q.mass < minm_q) || (in_q.mass > maxm_q);
		end
		if (cmd.dec) begin
			cand_q <= cand;
			soft_q <= soft_ok;
		end
		if (cmd.fin) area_q <= 23'(adx) * 23'(ady);
	end

	assign bound = lost_q ? {9'd0, lot_q} : ({9'd0, base_q} + {1'b0, bprod_q[25:8]});
	// window test as cx + bound < prev or cx > prev + bound
	assign xlo = {10'd0, in_q.center_x} + {1'b0, bound};
	assign ylo = {10'd0, in_q.center_y} + {1'b0, bound};
	assign xhi = {10'd0, prev_x_q} + {1'b0, bound};
	assign yhi = {10'd0, prev_y_q} + {1'b0, bound};

	assign lo   = $signed({10'd0, rmin_q, 8'd0}) + 34'(shift_q);
	assign hi   = $signed({10'd0, rmax_q, 8'd0}) + 34'(shift_q);
	assign numr = {h_q, 16'd0};

	always_comb begin
		priority if (w_q == 11'sd0) ratiobad = 1'b0;
		else if (!w_q[10]) ratiobad = (numr < low_q) || (numr > hiw_q);
		else ratiobad = (numr > low_q) || (numr < hiw_q);
	end

	assign cand    = !seen_q || !(massbad_q || killw_q || ratiobad);
	assign soft_ok = !seen_q || !massbad_q;

	assign msum = {1'b0, mass_acc_q} + {5'd0, in_q.mass};
	assign wxs  = {1'b0, wsum_x_q} + {11'd0, px_q};
	assign wys  = {1'b0, wsum_y_q} + {11'd0, py_q};

	assign adx = $signed({1'b0, br_q}) - $signed({1'b0, bl_q});
	assign ady = $signed({1'b0, bb_q}) - $signed({1'b0, bt_q});
	assign lost_nx = (mass_acc_q == 24'd0) || (area_q > AREA_LIM);

	bgmt_div u_div_x (
		.clk(clk), .arst_n(arst_n), .start(cmd.fin),
		.num(wsum_x_q), .den(mass_acc_q), .done(dx_done), .quot(qx)
	);
	bgmt_div u_div_y (
		.clk(clk), .arst_n(arst_n), .start(cmd.fin),
		.num(wsum_y_q), .den(mass_acc_q), .done(dy_done), .quot(qy)
	);

	// tracking and frame accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			lost_q     <= 1'b0;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
			mass_acc_q <= '0;
			wsum_x_q   <= '0;
			wsum_y_q   <= '0;
			bl_q       <= BOX_W0;
			bt_q       <= BOX_H0;
			br_q       <= '0;
			bb_q       <= '0;
		end else if (cmd.commit) begin
			seen_q     <= 1'b1;
			lost_q     <= lost_nx;
			if (mass_acc_q != 24'd0) begin
				prev_x_q <= qx;
				prev_y_q <= qy;
			end
			mass_acc_q <= '0;
			wsum_x_q   <= '0;
			wsum_y_q   <= '0;
			bl_q       <= BOX_W0;
			bt_q       <= BOX_H0;
			br_q       <= '0;
			bb_q       <= '0;
		end else if (cmd.dec && cand) begin
			mass_acc_q <= msum[24] ? MASS_MAX : msum[23:0];
			wsum_x_q   <= wxs[40] ? WSUM_MAX : wxs[39:0];
			wsum_y_q   <= wys[40] ? WSUM_MAX : wys[39:0];
			if (in_q.left_col < bl_q)   bl_q <= in_q.left_col;
			if (in_q.top_row < bt_q)    bt_q <= in_q.top_row;
			if (in_q.right_col > br_q)  br_q <= in_q.right_col;
			if (in_q.bottom_row > bb_q) bb_q <= in_q.bottom_row;
		end
	end

	logic out_ld_mid;
	assign out_ld_mid = cmd.dec && !in_q.last_blob;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else if (out_ld_mid || cmd.commit) result_valid <= 1'b1;
		else if (!result_stall) result_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_ld_mid) begin
			// gate flags on top, frame fields zero
			result <= {cand, soft_ok, !cand, 86'd0};
		end else if (cmd.commit) begin
			result.candidate      <= cand_q;
			result.soft_candidate <= soft_q;
			result.killed         <= !cand_q;
			result.track_x        <= (mass_acc_q != 24'd0) ? qx : prev_x_q;
			result.track_y        <= (mass_acc_q != 24'd0) ? qy : prev_y_q;
			result.box_left       <= bl_q;
			result.box_right      <= br_q;
			result.box_top        <= bt_q;
			result.box_bottom     <= bb_q;
			result.total_mass     <= mass_acc_q;
			result.lost_track     <= lost_nx;
			result.frame_done     <= 1'b1;
		end
	end

	assign stat.last     = in_q.last_blob;
	assign stat.out_busy = result_valid && result_stall;
	assign stat.div_done = dx_done && dy_done;

endmodule
`default_nettype wire

[sv/bgmt_ctrl.sv]
`default_nettype none
module bgmt_ctrl import bgmt_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  blob_valid,
	output logic       blob_stall,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;
	localparam logic [2:0] ST_MUL2 = 3'd2;
	localparam logic [2:0] ST_DEC  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;
	localparam logic [2:0] ST_DIVW = 3'd5;

	logic [2:0] state_q, state_nx;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (blob_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_nx = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_nx = ST_DEC;
			end
			ST_DEC: begin
				if (!stat.out_busy) begin
					cmd.dec  = 1'b1;
					state_nx = stat.last ? ST_FIN : ST_IDLE;
				end
			end
			ST_FIN: begin
				cmd.fin  = 1'b1;
				state_nx = ST_DIVW;
			end
			ST_DIVW: begin
				if (stat.div_done && !stat.out_busy) begin
					cmd.commit = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nx;
	end

	assign blob_stall = state_q != ST_IDLE;

endmodule
`default_nettype wire

[sv/blob_gate_and_merge_tracker.sv]
`default_nettype none
// blob gate and merge tracker: blobs of a frame arrive one per transfer with
// last_blob on the final one; each gets one result. after the first frame a
// blob is gated on mass, a window around the previous track center and its
// height over width ratio; passing blobs are merged into mass, weighted
// center sums and a box. a blob holds the input through capture, two
// multiplier stages and decide; decide registers the result, waiting while
// a result is stalled, but the last blob's result instead follows the two
// 40-step serial dividers that form the new center. one blob is in flight at
// a time; a waiting result does not block the next transfer in. the user
// must write configuration only while idle; the block does not enforce this.
module blob_gate_and_merge_tracker import bgmt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [19:0] cfg_data,
	input  wire logic        blob_valid,
	output logic             blob_stall,
	input  wire blob_t       blob,
	output logic             result_valid,
	input  wire logic        result_stall,
	output result_t          result
);

	cmd_t  cmd;
	stat_t stat;

	// sequencer
	bgmt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .blob_valid(blob_valid),
		.blob_stall(blob_stall), .stat(stat), .cmd(cmd)
	);

	// gates, accumulators, dividers and output register
	bgmt_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .blob(blob), .cmd(cmd), .stat(stat),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	// a taken blob keeps the input stalled on the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		blob_valid && !blob_stall |=> blob_stall)
		else $error("input not stalled after transfer");

	// killed is exactly the complement of candidate
	a_kill: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.killed != result.candidate)
		else $error("killed and candidate disagree");

	// a blob that fails the mass gate is never a candidate
	a_soft: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.soft_candidate |-> !result.candidate)
		else $error("candidate without mass gate");

	// frame fields are zero away from the last blob
	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.frame_done |->
		result.total_mass == 24'd0 && !result.lost_track)
		else $error("frame fields set mid frame");

endmodule
`default_nettype wire
